### rtl/eotr_pkg.sv
// Shared types, constants and tables of the engine-out thrust reallocation block.
`timescale 1ns / 1ps
package eotr_pkg;

  localparam int unsigned NCH    = 9;
  localparam int unsigned FAN_N  = 18;
  localparam int unsigned WKW    = 3;
  localparam int unsigned QHW    = 11;
  localparam int unsigned DHW    = 15;
  localparam int unsigned DVW    = DHW + 1;
  localparam int unsigned NUMW   = 29;
  localparam int unsigned QUOW   = 17;
  localparam int unsigned GW     = 16;
  localparam int unsigned SQW    = 16;
  localparam int unsigned CFG_IW = 3;
  localparam int unsigned CFG_DW = 9;
  localparam int unsigned ARM_IW = 8;

  localparam int unsigned NUM_SH_HI = 18;
  localparam int unsigned NUM_SH_LO = 15;

  localparam logic [QHW-1:0] QH_ONE       = 11'd256;
  localparam logic [QHW-1:0] QH_TWO       = 11'd512;
  localparam logic [DHW-1:0] DH_APPLY_MIN = 15'd3;
  localparam logic [DHW-1:0] DH_DIV_MIN   = 15'd1844;
  localparam logic [GW-1:0]  GAIN_MAX     = 16'hFFFF;
  localparam logic [GW-1:0]  GAIN_ONE     = 16'd8192;

  localparam logic [CFG_DW-1:0] AIL_BOOST_RST = 9'd128;
  localparam logic [CFG_DW-1:0] MID_MULT_RST  = 9'd128;

  typedef enum logic [CFG_IW-1:0] {
    CFG_AIL_BOOST  = 3'd0,
    CFG_MID_MULT   = 3'd1,
    CFG_BOOST_MID  = 3'd2,
    CFG_NO_MAKEUP  = 3'd3,
    CFG_ARM_FAILED = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ROLE_TIP,
    ROLE_AIL,
    ROLE_MID,
    ROLE_CTR
  } ch_role_e;

  localparam int unsigned CH_SIZE  [NCH] = '{1, 2, 2, 2, 4, 2, 2, 2, 1};
  localparam int unsigned CH_FIRST [NCH] = '{0, 1, 3, 5, 7, 11, 13, 15, 17};
  localparam ch_role_e    CH_ROLE  [NCH] = '{ROLE_TIP, ROLE_AIL, ROLE_MID, ROLE_MID, ROLE_CTR,
                                             ROLE_MID, ROLE_MID, ROLE_AIL, ROLE_TIP};
  localparam longint unsigned ARM_SQ [NCH] = '{
    64'd251222500, 64'd195300625, 64'd131675625, 64'd80550625, 64'd0,
    64'd80550625, 64'd131675625, 64'd195300625, 64'd251222500
  };

  typedef logic [SQW-1:0] arm_tbl_t [2**ARM_IW];

  function automatic arm_tbl_t build_arm_tbl();
    arm_tbl_t        tbl;
    longint unsigned sum;
    longint unsigned v;
    int unsigned     ch;
    for (int i = 0; i < 2**ARM_IW; i++) begin
      sum = 64'd0;
      for (int j = 0; j < ARM_IW; j++) begin
        ch = (j < 4) ? j : j + 1;
        if (((i >> j) & 1) != 0) sum = sum + ARM_SQ[ch];
      end
      v = (sum * 64'd4096 + 64'd50000000) / 64'd100000000;
      tbl[i] = (v > 64'd65535) ? '1 : v[SQW-1:0];
    end
    return tbl;
  endfunction

  localparam arm_tbl_t ARM_TBL = build_arm_tbl();

  typedef struct packed {
    logic [CFG_DW-1:0] ail_boost;
    logic [CFG_DW-1:0] mid_mult;
    logic              boost_mid;
    logic              no_makeup;
    logic              arm_failed;
  } cfg_t;

  typedef struct packed {
    logic [NCH-1:0][QHW-1:0] qh;
    logic [NCH-1:0]          alive;
    logic                    apply;
    logic                    big;
    logic                    arm_ok;
  } side_t;

  typedef struct packed {
    logic [NCH-1:0][NUMW-1:0] num;
    logic [DVW-1:0]           den;
    side_t                    side;
  } div_in_t;

  typedef struct packed {
    logic [DVW-1:0]  rem;
    logic [NUMW-1:0] num;
    logic [QUOW-1:0] quo;
  } div_lane_t;

  typedef struct packed {
    div_lane_t [NCH-1:0] lane;
    logic [DVW-1:0]      den;
    side_t               side;
  } div_stage_t;

endpackage

### rtl/eotr_if.sv
// Item channel interfaces of the engine-out thrust reallocation block.
`timescale 1ns / 1ps
interface eotr_in_if;
  import eotr_pkg::*;
  logic             valid;
  logic             ready;
  logic [FAN_N-1:0] failure_mask;
  modport source (output valid, output failure_mask, input ready);
  modport sink (input valid, input failure_mask, output ready);
endinterface

interface eotr_out_if;
  import eotr_pkg::*;
  logic           valid;
  logic           ready;
  logic [GW-1:0]  gain_ch1;
  logic [GW-1:0]  gain_ch2;
  logic [GW-1:0]  gain_ch3;
  logic [GW-1:0]  gain_ch4;
  logic [GW-1:0]  gain_ch5;
  logic [GW-1:0]  gain_ch6;
  logic [GW-1:0]  gain_ch7;
  logic [GW-1:0]  gain_ch8;
  logic [GW-1:0]  gain_ch9;
  logic [NCH-1:0] alive_flags;
  logic [SQW-1:0] arm_sq_sum;
  logic           arm_permitted;
  modport source (output valid, output gain_ch1, output gain_ch2, output gain_ch3,
                  output gain_ch4, output gain_ch5, output gain_ch6, output gain_ch7,
                  output gain_ch8, output gain_ch9, output alive_flags, output arm_sq_sum,
                  output arm_permitted, input ready);
  modport sink (input valid, input gain_ch1, input gain_ch2, input gain_ch3,
                input gain_ch4, input gain_ch5, input gain_ch6, input gain_ch7,
                input gain_ch8, input gain_ch9, input alive_flags, input arm_sq_sum,
                input arm_permitted, output ready);
endinterface

### rtl/eotr_scale.sv
// Front pipeline: mask decode, channel gains, delivered thrust and divider operands.
`timescale 1ns / 1ps
module eotr_scale (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  eotr_pkg::cfg_t             cfg_i,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  logic [eotr_pkg::FAN_N-1:0] mask_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output eotr_pkg::div_in_t          data_o
);
  import eotr_pkg::*;

  localparam int unsigned NST = 3;

  logic [NST-1:0] v_q;
  logic [NST-1:0] adv;

  logic [WKW-1:0] fail [NCH];
  logic [WKW-1:0] work [NCH];
  logic [NCH-1:0] part;
  logic [NCH-1:0] mdead;
  logic [NCH-1:0] alive;
  logic [QHW-1:0] qh [NCH];
  logic [QHW-2:0] ail_scaled;
  logic           arm_ok;

  logic [WKW-1:0] work_q [NCH];
  logic [QHW-1:0] qh1_q [NCH];
  logic [NCH-1:0] alive1_q;
  logic           arm1_q;

  logic [DHW-1:0] dh_sum;
  logic [QHW-1:0] qh2_q [NCH];
  logic [NCH-1:0] alive2_q;
  logic           arm2_q;
  logic [DHW-1:0] dh_q;

  div_in_t        prep;
  div_in_t        data_q;

  always_comb begin
    for (int i = 0; i < NST; i++) begin
      adv[i] = ready_i || !(&(v_q | NST'((1 << i) - 1)));
    end
  end

  assign ail_scaled = (QHW-1)'(256) + (QHW-1)'(cfg_i.ail_boost);
  assign arm_ok     = (mask_i == '0) || cfg_i.arm_failed;

  always_comb begin
    for (int k = 0; k < NCH; k++) begin
      fail[k] = '0;
      for (int e = 0; e < CH_SIZE[k]; e++) begin
        fail[k] = fail[k] + WKW'(mask_i[CH_FIRST[k] + e]);
      end
      work[k] = WKW'(CH_SIZE[k]) - fail[k];
    end
    for (int k = 0; k < NCH; k++) begin
      part[k]  = (work[k] != '0) && (work[k] != WKW'(CH_SIZE[k]));
      mdead[k] = (work[NCH-1-k] == '0);
      alive[k] = (work[k] != '0) && !((CH_ROLE[k] == ROLE_TIP) && mdead[k]);
      case (CH_ROLE[k])
        ROLE_TIP: begin
          qh[k] = ((work[k] != '0) && mdead[k]) ? '0 : QH_ONE;
        end
        ROLE_AIL: begin
          if (mdead[k] && alive[k]) begin
            qh[k] = part[k] ? {ail_scaled, 1'b0} : {1'b0, ail_scaled};
          end else begin
            qh[k] = part[k] ? QH_TWO : QH_ONE;
          end
        end
        ROLE_MID: begin
          if (mdead[k] && alive[k]) begin
            qh[k] = (part[k] && cfg_i.boost_mid) ? {1'b0, cfg_i.mid_mult, 1'b0}
                                                 : {2'b0, cfg_i.mid_mult};
          end else begin
            qh[k] = (part[k] && cfg_i.boost_mid) ? QH_TWO : QH_ONE;
          end
        end
        default: begin
          qh[k] = QH_ONE;
        end
      endcase
    end
  end

  always_comb begin
    dh_sum = '0;
    for (int k = 0; k < NCH; k++) begin
      if (alive1_q[k]) dh_sum = dh_sum + DHW'(work_q[k]) * DHW'(qh1_q[k]);
    end
  end

  always_comb begin
    for (int k = 0; k < NCH; k++) begin
      prep.num[k]     = (NUMW'(qh2_q[k]) << NUM_SH_HI) + (NUMW'(qh2_q[k]) << NUM_SH_LO)
                        + NUMW'(dh_q);
      prep.side.qh[k] = qh2_q[k];
    end
    prep.den         = {dh_q, 1'b0};
    prep.side.alive  = alive2_q;
    prep.side.apply  = !cfg_i.no_makeup && (dh_q >= DH_APPLY_MIN);
    prep.side.big    = (dh_q >= DH_DIV_MIN);
    prep.side.arm_ok = arm2_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) v_q[0] <= valid_i;
      for (int i = 1; i < NST; i++) begin
        if (adv[i]) v_q[i] <= v_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      work_q   <= work;
      qh1_q    <= qh;
      alive1_q <= alive;
      arm1_q   <= arm_ok;
    end
    if (adv[1]) begin
      qh2_q    <= qh1_q;
      alive2_q <= alive1_q;
      arm2_q   <= arm1_q;
      dh_q     <= dh_sum;
    end
    if (adv[2]) begin
      data_q <= prep;
    end
  end

  assign ready_o = adv[0];
  assign valid_o = v_q[NST-1];
  assign data_o  = data_q;

endmodule

### rtl/eotr_div.sv
// Pipelined restoring divider, one quotient bit per stage, nine lanes on a shared divisor.
`timescale 1ns / 1ps
module eotr_div (
  input  logic                                            clk_i,
  input  logic                                            rst_ni,
  input  logic                                            valid_i,
  output logic                                            ready_o,
  input  eotr_pkg::div_in_t                               data_i,
  output logic                                            valid_o,
  input  logic                                            ready_i,
  output logic [eotr_pkg::NCH-1:0][eotr_pkg::QUOW-1:0]    quo_o,
  output eotr_pkg::side_t                                 side_o
);
  import eotr_pkg::*;

  logic [QUOW-1:0] v_q;
  logic [QUOW-1:0] adv;

  div_stage_t init;
  div_stage_t src  [QUOW];
  div_stage_t nxt  [QUOW];
  div_stage_t st_q [QUOW];

  always_comb begin
    for (int i = 0; i < QUOW; i++) begin
      adv[i] = ready_i || !(&(v_q | QUOW'((1 << i) - 1)));
    end
  end

  always_comb begin
    for (int k = 0; k < NCH; k++) begin
      init.lane[k].rem = DVW'(data_i.num[k][NUMW-1:QUOW]);
      init.lane[k].num = data_i.num[k];
      init.lane[k].quo = '0;
    end
    init.den  = data_i.den;
    init.side = data_i.side;
  end

  for (genvar s = 0; s < QUOW; s++) begin : g_stage
    logic [DVW:0]   trial [NCH];
    logic [NCH-1:0] ge;

    if (s == 0) begin : g_first
      assign src[s] = init;
    end else begin : g_next
      assign src[s] = st_q[s-1];
    end

    always_comb begin
      nxt[s] = src[s];
      for (int k = 0; k < NCH; k++) begin
        trial[k] = {src[s].lane[k].rem, src[s].lane[k].num[QUOW-1-s]};
        ge[k]    = (trial[k] >= {1'b0, src[s].den});
        nxt[s].lane[k].rem = ge[k] ? DVW'(trial[k] - {1'b0, src[s].den}) : DVW'(trial[k]);
        nxt[s].lane[k].quo = {src[s].lane[k].quo[QUOW-2:0], ge[k]};
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[s]) st_q[s] <= nxt[s];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) v_q[0] <= valid_i;
      for (int i = 1; i < QUOW; i++) begin
        if (adv[i]) v_q[i] <= v_q[i-1];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NCH; k++) begin
      quo_o[k] = st_q[QUOW-1].lane[k].quo;
    end
  end

  assign side_o  = st_q[QUOW-1].side;
  assign ready_o = adv[0];
  assign valid_o = v_q[QUOW-1];

endmodule

### rtl/engine_out_thrust_reallocation.sv
// Top level of the engine-out thrust reallocation block: registers, pipeline and result stage.
//
//   channel   dir  payload                                      accepted when
//   in_i      in   failure_mask[17:0]                           valid && ready
//   out_o     out  gain_ch1..9, alive_flags, arm_sq_sum,        valid && ready
//                  arm_permitted
//   cfg       in   cfg_we_i, cfg_idx_i[2:0], cfg_wdata_i[8:0]   cfg_we_i
//
// One item per cycle sustained while out_o.ready holds; the path runs through 3 front
// stages, 17 divider stages (one quotient bit each) and the result register.
// Every stage holds its own valid bit; a stalled output fills bubbles upstream
// before in_i.ready drops. Reset clears all valid bits and loads register defaults.
`timescale 1ns / 1ps
module engine_out_thrust_reallocation (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [eotr_pkg::CFG_IW-1:0] cfg_idx_i,
  input  logic [eotr_pkg::CFG_DW-1:0] cfg_wdata_i,
  eotr_in_if.sink                     in_i,
  eotr_out_if.source                  out_o
);
  import eotr_pkg::*;

  cfg_t cfg_q;

  logic                     scale_ready;
  logic                     scale_valid;
  div_in_t                  scale_data;
  logic                     div_ready;
  logic                     div_valid;
  logic [NCH-1:0][QUOW-1:0] div_quo;
  side_t                    div_side;

  logic                     adv_out;
  logic [QUOW-1:0]          mk [NCH];
  logic [GW-1:0]            gain [NCH];
  logic [ARM_IW-1:0]        arm_idx;

  logic                     out_v_q;
  logic [GW-1:0]            gain_q [NCH];
  logic [NCH-1:0]           alive_q;
  logic [SQW-1:0]           sq_q;
  logic                     perm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ail_boost  <= AIL_BOOST_RST;
      cfg_q.mid_mult   <= MID_MULT_RST;
      cfg_q.boost_mid  <= 1'b0;
      cfg_q.no_makeup  <= 1'b0;
      cfg_q.arm_failed <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_AIL_BOOST:  cfg_q.ail_boost  <= cfg_wdata_i;
        CFG_MID_MULT:   cfg_q.mid_mult   <= cfg_wdata_i;
        CFG_BOOST_MID:  cfg_q.boost_mid  <= cfg_wdata_i[0];
        CFG_NO_MAKEUP:  cfg_q.no_makeup  <= cfg_wdata_i[0];
        CFG_ARM_FAILED: cfg_q.arm_failed <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  eotr_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .valid_i (in_i.valid),
    .ready_o (scale_ready),
    .mask_i  (in_i.failure_mask),
    .valid_o (scale_valid),
    .ready_i (div_ready),
    .data_o  (scale_data)
  );

  eotr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (scale_valid),
    .ready_o (div_ready),
    .data_i  (scale_data),
    .valid_o (div_valid),
    .ready_i (adv_out),
    .quo_o   (div_quo),
    .side_o  (div_side)
  );

  assign in_i.ready = scale_ready;
  assign adv_out    = !out_v_q || out_o.ready;
  assign arm_idx    = {div_side.alive[NCH-1:5], div_side.alive[3:0]};

  always_comb begin
    for (int k = 0; k < NCH; k++) begin
      mk[k] = (QUOW'(div_side.qh[k]) << 6) + (QUOW'(div_side.qh[k]) << 4);
      if (div_side.apply && div_side.alive[k]) begin
        if (div_side.big) begin
          gain[k] = div_quo[k][QUOW-1] ? GAIN_MAX : div_quo[k][GW-1:0];
        end else begin
          gain[k] = mk[k][QUOW-1] ? GAIN_MAX : mk[k][GW-1:0];
        end
      end else begin
        gain[k] = {div_side.qh[k], 5'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv_out) begin
      out_v_q <= div_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_out) begin
      gain_q  <= gain;
      alive_q <= div_side.alive;
      sq_q    <= ARM_TBL[arm_idx];
      perm_q  <= div_side.arm_ok;
    end
  end

  assign out_o.valid         = out_v_q;
  assign out_o.gain_ch1      = gain_q[0];
  assign out_o.gain_ch2      = gain_q[1];
  assign out_o.gain_ch3      = gain_q[2];
  assign out_o.gain_ch4      = gain_q[3];
  assign out_o.gain_ch5      = gain_q[4];
  assign out_o.gain_ch6      = gain_q[5];
  assign out_o.gain_ch7      = gain_q[6];
  assign out_o.gain_ch8      = gain_q[7];
  assign out_o.gain_ch9      = gain_q[8];
  assign out_o.alive_flags   = alive_q;
  assign out_o.arm_sq_sum    = sq_q;
  assign out_o.arm_permitted = perm_q;

  a_tip_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> alive_q[0] == alive_q[NCH-1])
    else $error("wingtip channels disagree on alive");

  a_dead_aileron: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !alive_q[1] |-> gain_q[1] == GAIN_ONE)
    else $error("dead aileron channel gain is not unity");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(div_valid))
    else $error("result item appeared without a divider item");

endmodule
